// ----- hdl/ssrd_pkg.sv -----
// ============================================================================
// ssrd_pkg - shared types and constants of the sprite scanline RLE decoder
// Transaction payloads, configuration record, result codes and helpers.
// ============================================================================
package ssrd_pkg;

    // Largest frame dimension plus one; dimensions are capped below it
    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 12;

    // APB register file geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Reset values of the configuration registers
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd64;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd64;
    localparam logic             SHADOW_MODE_RST  = 1'b0;
    localparam logic [7:0]       SHADOW_INDEX_RST = 8'd47;

    // Opaque counts keep their low seven bits
    localparam logic [7:0] OPAQUE_MASK = 8'h7F;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SHADOW_MODE  = 2'd2,
        REG_SHADOW_INDEX = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_SKIP    = 2'd0,
        KIND_FILL    = 2'd1,
        KIND_LITERAL = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERRUN   = 2'd1,
        ERR_EARLY_END = 2'd2
    } err_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic             shadow_mode;
        logic [7:0]       shadow_index;
    } cfg_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       picture_last;
    } in_t;

    typedef struct packed {
        kind_t            kind;
        logic [DIM_W-1:0] pos_x;
        logic [DIM_W-1:0] pos_y;
        logic [7:0]       run_length;
        logic [7:0]       pixel_value;
        logic             line_end;
        logic             frame_end;
        err_t             error_code;
    } out_t;

    // Clamp a frame dimension to MAX_DIM - 1
    function automatic logic [DIM_W-1:0] cap_dim(input logic [DIM_W-1:0] v);
        if (32'(v) > MAX_DIM - 1) begin
            return DIM_W'(MAX_DIM - 1);
        end
        return v;
    endfunction

endpackage

// ----- hdl/ssrd_apb_regs.sv -----
// ============================================================================
// ssrd_apb_regs - APB configuration registers
// Holds frame width, frame height, shadow mode and shadow index.
// ============================================================================
module ssrd_apb_regs
    import ssrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Decode the write into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[DIM_W-1:0];
                REG_SHADOW_MODE:  cfg_next.shadow_mode  = pwdata[0];
                REG_SHADOW_INDEX: cfg_next.shadow_index = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
            cfg_reg.shadow_mode  <= SHADOW_MODE_RST;
            cfg_reg.shadow_index <= SHADOW_INDEX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_reg.frame_height);
            REG_SHADOW_MODE:  prdata = APB_DATA_W'(cfg_reg.shadow_mode);
            REG_SHADOW_INDEX: prdata = APB_DATA_W'(cfg_reg.shadow_index);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- hdl/ssrd_in_reg.sv -----
// ============================================================================
// ssrd_in_reg - input register stage
// Captures a code byte per cycle ahead of the decode stage unless it stalls.
// ============================================================================
module ssrd_in_reg
    import ssrd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic item_valid,
    output in_t  item,
    input  logic item_take
);

    logic valid_reg;
    logic valid_next;
    in_t  data_reg;

    // Accept whenever the stage is empty or drains this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the decode stage takes it
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// ----- hdl/ssrd_decode.sv -----
// ============================================================================
// ssrd_decode - scanline run decode stage and result register
// Tracks column, line and run parity; each byte yields at most one command.
// ============================================================================
module ssrd_decode
    import ssrd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic item_valid,
    input  in_t  item,
    output logic item_take,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    logic [DIM_W-1:0] column_reg, column_next;
    logic [DIM_W-1:0] line_reg, line_next;
    logic             parity_reg, parity_next;
    logic [6:0]       lit_left_reg, lit_left_next;
    logic             done_reg, done_next;
    logic             err_reg, err_next;
    logic             m_valid_reg, m_valid_next;
    out_t             result_reg, result_next;

    // Advance when a byte waits and the result register is free
    assign item_take = item_valid && (!m_valid_reg || m_ready);

    // Decode one byte against the current scanline state
    always_comb begin
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [7:0]       cnt;
        logic [DIM_W:0]   run_end;
        logic             finish;

        width         = cap_dim(cfg.frame_width);
        height        = cap_dim(cfg.frame_height);
        column_next   = column_reg;
        line_next     = line_reg;
        parity_next   = parity_reg;
        lit_left_next = lit_left_reg;
        done_next     = done_reg;
        err_next      = err_reg;
        finish        = 1'b0;
        cnt           = parity_reg ? (item.code_byte & OPAQUE_MASK) : item.code_byte;
        run_end       = {1'b0, column_reg} + (DIM_W+1)'(cnt);

        result_next            = '0;
        result_next.kind       = KIND_NONE;
        result_next.error_code = ERR_NONE;

        if (!done_reg && !err_reg) begin
            result_next.pos_x = column_reg;
            result_next.pos_y = line_reg;
            if (lit_left_reg != 7'd0) begin
                // Literal pixel inside an opaque run
                result_next.kind        = KIND_LITERAL;
                result_next.run_length  = 8'd1;
                result_next.pixel_value = item.code_byte;
                column_next             = column_reg + DIM_W'(1);
                lit_left_next           = lit_left_reg - 7'd1;
                finish                  = (lit_left_reg == 7'd1);
            end else if (run_end > {1'b0, width}) begin
                // Run would pass the line width
                result_next.error_code = ERR_OVERRUN;
                err_next               = 1'b1;
            end else if (!parity_reg) begin
                result_next.kind       = KIND_SKIP;
                result_next.run_length = cnt;
                column_next            = run_end[DIM_W-1:0];
                finish                 = 1'b1;
            end else if (cfg.shadow_mode) begin
                result_next.kind        = KIND_FILL;
                result_next.run_length  = cnt;
                result_next.pixel_value = cfg.shadow_index;
                column_next             = run_end[DIM_W-1:0];
                finish                  = 1'b1;
            end else if (cnt == 8'd0) begin
                finish = 1'b1;
            end else begin
                // Open a literal run; the count byte itself emits nothing
                lit_left_next = cnt[6:0];
            end

            // Close the run and wrap the line at the frame width
            if (finish) begin
                parity_next = !parity_reg;
                if (column_next == width) begin
                    result_next.line_end = 1'b1;
                    column_next          = '0;
                    parity_next          = 1'b0;
                    if (({1'b0, line_reg} + (DIM_W+1)'(1)) >= {1'b0, height}) begin
                        result_next.frame_end = 1'b1;
                        done_next             = 1'b1;
                    end else begin
                        line_next = line_reg + DIM_W'(1);
                    end
                end
            end
        end

        // Picture boundary: flag a short picture, then drop all state
        if (item.picture_last) begin
            if (!done_next && !err_next) begin
                result_next.error_code = ERR_EARLY_END;
            end
            column_next   = '0;
            line_next     = '0;
            parity_next   = 1'b0;
            lit_left_next = '0;
            done_next     = 1'b0;
            err_next      = 1'b0;
        end
    end

    assign m_valid_next = item_take ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            line_reg     <= '0;
            parity_reg   <= 1'b0;
            lit_left_reg <= '0;
            done_reg     <= 1'b0;
            err_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (item_take) begin
                column_reg   <= column_next;
                line_reg     <= line_next;
                parity_reg   <= parity_next;
                lit_left_reg <= lit_left_next;
                done_reg     <= done_next;
                err_reg      <= err_next;
            end
        end
    end

    // Load the result register on each decoded byte
    always_ff @(posedge aclk) begin
        if (item_take) begin
            result_reg <= result_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = result_reg;

endmodule

// ----- hdl/sprite_scanline_rle_decoder.sv -----
// ============================================================================
// sprite_scanline_rle_decoder - sprite scanline run-length decoder
// Turns a compressed sprite byte stream into skip, fill and pixel commands.
// ============================================================================
// Path: an accepted byte enters the input register, then the decode stage
//   writes the result register and raises m_valid.
// Throughput: one byte per cycle unless m_ready stalls (single decode stage).
// Reset: synchronous, active low; empties both registers, clears the
//   scanline state and loads the configuration registers with their defaults.
module sprite_scanline_rle_decoder
    import ssrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_payload,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    logic item_valid;
    logic item_take;
    in_t  item;

    ssrd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssrd_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ssrd_decode u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

// ----- hdl/ssrd_checker.sv -----
// ============================================================================
// ssrd_checker - port-level checks of the sprite scanline RLE decoder
// Watches the result channel for stalls and consistent command fields.
// ============================================================================
module ssrd_checker
    import ssrd_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    // Hold a stalled result transaction
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result transaction dropped or changed while stalled");

    // A literal pixel always covers exactly one pixel
    a_lit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == KIND_LITERAL |-> m_payload.run_length == 8'd1)
        else $error("literal pixel with run length other than one");

    // An overrun emits nothing and never closes a line
    a_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.error_code == ERR_OVERRUN
            |-> m_payload.kind == KIND_NONE && !m_payload.line_end)
        else $error("overrun result carries a command or a line end");

    // The frame closes only together with its last line
    a_frame_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.frame_end |-> m_payload.line_end
            && m_payload.error_code != ERR_EARLY_END)
        else $error("frame end without line end, or flagged as short");

endmodule

bind sprite_scanline_rle_decoder ssrd_checker u_ssrd_checker (.*);
